>>> rtl/cdll_pkg.sv
// Shared types and codes for the cursor doubly linked list.
`timescale 1ns / 1ps

package cdll_pkg;

	// Input beat: one command and its data word
	typedef struct packed {
		logic [4:0]         command;
		logic signed [31:0] value;
	} cdll_req_t;

	// Output beat: one result per command
	typedef struct packed {
		logic signed [31:0] read_value;
		logic               read_valid;
		logic [1:0]         error;
		logic               cursor_active;
	} cdll_rsp_t;

	localparam logic [4:0] CMD_CLEAR       = 5'd0;
	localparam logic [4:0] CMD_INS_FIRST   = 5'd1;
	localparam logic [4:0] CMD_INS_LAST    = 5'd2;
	localparam logic [4:0] CMD_TO_FIRST    = 5'd3;
	localparam logic [4:0] CMD_TO_LAST     = 5'd4;
	localparam logic [4:0] CMD_READ_FIRST  = 5'd5;
	localparam logic [4:0] CMD_READ_LAST   = 5'd6;
	localparam logic [4:0] CMD_DEL_FIRST   = 5'd7;
	localparam logic [4:0] CMD_DEL_LAST    = 5'd8;
	localparam logic [4:0] CMD_DEL_AFTER   = 5'd9;
	localparam logic [4:0] CMD_DEL_BEFORE  = 5'd10;
	localparam logic [4:0] CMD_INS_AFTER   = 5'd11;
	localparam logic [4:0] CMD_INS_BEFORE  = 5'd12;
	localparam logic [4:0] CMD_READ_CURSOR = 5'd13;
	localparam logic [4:0] CMD_OVERWRITE   = 5'd14;
	localparam logic [4:0] CMD_STEP_NEXT   = 5'd15;
	localparam logic [4:0] CMD_STEP_PREV   = 5'd16;

	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_FULL  = 2'd1;
	localparam logic [1:0] ERR_EMPTY = 2'd2;

	// Datapath step requested by the controller
	typedef enum logic [2:0] {
		OP_IDLE,
		OP_DEC,
		OP_TAKE,
		OP_RD1,
		OP_RD2,
		OP_WR1,
		OP_WR2
	} cdll_op_t;

	typedef struct packed {
		cdll_op_t op;
		logic     latch;
		logic     finish;
	} cdll_ctl_t;

	// Step plan reported during decode, plus early exit at the second read step
	typedef struct packed {
		logic need_take;
		logic need_rd1;
		logic need_rd2;
		logic need_wr1;
		logic need_wr2;
		logic abort;
	} cdll_stat_t;

endpackage

>>> rtl/cdll_ctrl.sv
// Sequencer: walks decode, free-list pop, link reads and link writes.
`timescale 1ns / 1ps

module cdll_ctrl import cdll_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  cdll_stat_t stat,
	output cdll_ctl_t  ctl,
	output logic       busy
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DEC,
		S_TAKE,
		S_RD1,
		S_RD2,
		S_WR1,
		S_WR2
	} state_t;

	state_t     state_q, state_d;
	cdll_stat_t plan_q, plan;
	state_t     after_take, after_rd1, after_rd2, after_wr1;

	always_comb begin
		plan       = (state_q == S_DEC) ? stat : plan_q;
		after_wr1  = plan.need_wr2 ? S_WR2 : S_IDLE;
		after_rd2  = plan.need_wr1 ? S_WR1 : after_wr1;
		after_rd1  = plan.need_rd2 ? S_RD2 : after_rd2;
		after_take = plan.need_rd1 ? S_RD1 : after_rd1;
		unique case (state_q)
			S_IDLE: state_d = start ? S_DEC : S_IDLE;
			S_DEC:  state_d = plan.need_take ? S_TAKE : after_take;
			S_TAKE: state_d = after_take;
			S_RD1:  state_d = after_rd1;
			S_RD2:  state_d = stat.abort ? S_IDLE : after_rd2;
			S_WR1:  state_d = after_wr1;
			S_WR2:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ctl.latch  = (state_q == S_IDLE) && start;
		ctl.finish = (state_q != S_IDLE) && (state_d == S_IDLE);
		unique case (state_q)
			S_IDLE: ctl.op = OP_IDLE;
			S_DEC:  ctl.op = OP_DEC;
			S_TAKE: ctl.op = OP_TAKE;
			S_RD1:  ctl.op = OP_RD1;
			S_RD2:  ctl.op = OP_RD2;
			S_WR1:  ctl.op = OP_WR1;
			S_WR2:  ctl.op = OP_WR2;
			default: ctl.op = OP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy    <= 1'b0;
			plan_q  <= '0;
		end else begin
			state_q <= state_d;
			busy    <= (state_d != S_IDLE);
			if (state_q == S_DEC) begin
				plan_q <= stat;
			end
		end
	end

endmodule

>>> rtl/cdll_dp.sv
// Datapath: node pool memories, list pointers, free list and result register.
`timescale 1ns / 1ps

module cdll_dp import cdll_pkg::*; #(
	parameter int NODES      = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cdll_req_t  request,
	input  cdll_ctl_t  ctl,
	output cdll_stat_t stat,
	output logic       done,
	output cdll_rsp_t  response
);

	localparam int IW = $clog2(NODES + 1);
	localparam int AW = $clog2(NODES);
	localparam logic [IW-1:0] NIL = IW'(NODES);

	typedef logic [IW-1:0] idx_t;

	function automatic logic ok(input idx_t i);
		return i < NIL;
	endfunction

	function automatic idx_t norm(input idx_t i);
		return (i < NIL) ? i : NIL;
	endfunction

	// single-port node stores
	logic [DATA_WIDTH-1:0] val_mem [NODES];
	idx_t                  nxt_mem [NODES];
	idx_t                  prv_mem [NODES];

	logic                  val_we, val_re, nxt_we, nxt_re, prv_we, prv_re;
	idx_t                  val_a, nxt_a, prv_a, nxt_d, prv_d;
	logic [DATA_WIDTH-1:0] val_d, val_rd;
	idx_t                  nxt_rd, prv_rd;

	cdll_req_t req_q;
	idx_t      head_q, tail_q, cur_q, fh_q, fresh_q, n_q, t_q, u_q;
	idx_t      head_d, tail_d, cur_d, fh_d, fresh_d, n_d, t_d, u_d;
	logic      take_q, take_d;
	cdll_rsp_t res_q, res_d;

	logic [4:0]            cmd;
	logic [DATA_WIDTH-1:0] v_dw;
	logic                  is_read, dir_next, del_ab, is_step;
	logic                  ins, full, ins_cur, da_ok, db_ok, rd_ok;
	idx_t                  rd_idx, lrd;

	// decode and plan
	always_comb begin
		cmd      = req_q.command;
		v_dw     = DATA_WIDTH'($signed(req_q.value));
		is_read  = (cmd == CMD_READ_FIRST) || (cmd == CMD_READ_LAST) ||
			(cmd == CMD_READ_CURSOR);
		rd_idx   = (cmd == CMD_READ_FIRST) ? head_q :
			(cmd == CMD_READ_LAST) ? tail_q : cur_q;
		rd_ok    = is_read && ok(rd_idx);
		dir_next = (cmd == CMD_DEL_FIRST) || (cmd == CMD_DEL_AFTER) ||
			(cmd == CMD_INS_AFTER) || (cmd == CMD_STEP_NEXT);
		lrd      = dir_next ? nxt_rd : prv_rd;
		del_ab   = (cmd == CMD_DEL_AFTER) || (cmd == CMD_DEL_BEFORE);
		is_step  = (cmd == CMD_STEP_NEXT) || (cmd == CMD_STEP_PREV);
		ins_cur  = ((cmd == CMD_INS_AFTER) || (cmd == CMD_INS_BEFORE)) && ok(cur_q);
		ins      = (cmd == CMD_INS_FIRST) || (cmd == CMD_INS_LAST) || ins_cur;
		full     = ins && !ok(fh_q) && !ok(fresh_q);
		da_ok    = (cmd == CMD_DEL_AFTER) && ok(cur_q) && (cur_q != tail_q);
		db_ok    = (cmd == CMD_DEL_BEFORE) && ok(cur_q) && (cur_q != head_q);

		stat.need_take = ins && ok(fh_q);
		stat.need_rd1  = rd_ok || ((cmd == CMD_DEL_FIRST) && ok(head_q)) ||
			((cmd == CMD_DEL_LAST) && ok(tail_q)) || da_ok || db_ok ||
			(ins_cur && !full) || (is_step && ok(cur_q));
		stat.need_rd2  = rd_ok || da_ok || db_ok || (is_step && ok(cur_q));
		stat.need_wr1  = (ins && !full) || ((cmd == CMD_DEL_FIRST) && ok(head_q)) ||
			((cmd == CMD_DEL_LAST) && ok(tail_q)) || da_ok || db_ok;
		stat.need_wr2  = (ins && !full) || ((cmd == CMD_DEL_LAST) && ok(tail_q)) ||
			da_ok || db_ok;
		stat.abort     = del_ab && !ok(lrd);
	end

	// step execution
	always_comb begin
		head_d  = head_q;
		tail_d  = tail_q;
		cur_d   = cur_q;
		fresh_d = fresh_q;
		n_d     = n_q;
		t_d     = t_q;
		u_d     = u_q;
		take_d  = 1'b0;
		// a pop from the free list lands in the cycle after its read
		fh_d    = take_q ? norm(nxt_rd) : fh_q;
		val_we  = 1'b0; val_re = 1'b0; val_a = cur_q; val_d = v_dw;
		nxt_we  = 1'b0; nxt_re = 1'b0; nxt_a = cur_q; nxt_d = NIL;
		prv_we  = 1'b0; prv_re = 1'b0; prv_a = cur_q; prv_d = NIL;
		res_d   = '0;

		unique case (ctl.op)
			OP_IDLE: begin
			end
			OP_DEC: begin
				if (cmd == CMD_CLEAR) begin
					head_d  = NIL;
					tail_d  = NIL;
					cur_d   = NIL;
					fh_d    = NIL;
					fresh_d = '0;
				end
				if (cmd == CMD_TO_FIRST) cur_d = norm(head_q);
				if (cmd == CMD_TO_LAST)  cur_d = norm(tail_q);
				if ((cmd == CMD_OVERWRITE) && ok(cur_q)) begin
					val_we = 1'b1;
					val_a  = cur_q;
				end
				if (ins && !ok(fh_q) && ok(fresh_q)) begin
					n_d     = fresh_q;
					fresh_d = IW'(fresh_q + IW'(1));
				end
				if ((cmd == CMD_DEL_FIRST) && ok(head_q)) begin
					t_d = head_q;
					if (cur_q == head_q) cur_d = NIL;
				end
				if ((cmd == CMD_DEL_LAST) && ok(tail_q)) begin
					t_d = tail_q;
					if (cur_q == tail_q) cur_d = NIL;
				end
				if (full) begin
					res_d.error = ERR_FULL;
				end else if (is_read && !rd_ok) begin
					res_d.error = ERR_EMPTY;
				end
			end
			OP_TAKE: begin
				n_d    = fh_q;
				nxt_re = 1'b1;
				nxt_a  = fh_q;
				take_d = 1'b1;
			end
			OP_RD1: begin
				if (is_read) begin
					val_re = 1'b1;
					val_a  = rd_idx;
				end else if (dir_next) begin
					nxt_re = 1'b1;
					nxt_a  = (cmd == CMD_DEL_FIRST) ? t_q : cur_q;
				end else begin
					prv_re = 1'b1;
					prv_a  = (cmd == CMD_DEL_LAST) ? t_q : cur_q;
				end
			end
			OP_RD2: begin
				if (is_read) begin
					res_d.read_value = 32'($signed(val_rd));
					res_d.read_valid = 1'b1;
				end
				if (is_step) cur_d = norm(lrd);
				if (del_ab) begin
					t_d = lrd;
					if (ok(lrd)) begin
						if (dir_next) begin
							nxt_re = 1'b1;
							nxt_a  = lrd;
						end else begin
							prv_re = 1'b1;
							prv_a  = lrd;
						end
					end
				end
			end
			OP_WR1: begin
				unique case (cmd)
					CMD_INS_FIRST: begin
						val_we = 1'b1; val_a = n_q;
						prv_we = 1'b1; prv_a = n_q; prv_d = NIL;
						nxt_we = 1'b1; nxt_a = n_q; nxt_d = head_q;
						u_d    = head_q;
						head_d = n_q;
						if (!ok(head_q)) tail_d = n_q;
					end
					CMD_INS_LAST: begin
						val_we = 1'b1; val_a = n_q;
						nxt_we = 1'b1; nxt_a = n_q; nxt_d = NIL;
						prv_we = 1'b1; prv_a = n_q; prv_d = tail_q;
						u_d    = tail_q;
						tail_d = n_q;
						if (!ok(tail_q)) head_d = n_q;
					end
					CMD_DEL_FIRST: begin
						if (t_q == tail_q) begin
							head_d = NIL;
							tail_d = NIL;
						end else begin
							head_d = nxt_rd;
							if (ok(nxt_rd)) begin
								prv_we = 1'b1; prv_a = nxt_rd; prv_d = NIL;
							end
						end
						nxt_we = 1'b1; nxt_a = t_q; nxt_d = fh_q;
						fh_d   = t_q;
					end
					CMD_DEL_LAST: begin
						if (t_q == head_q) begin
							head_d = NIL;
							tail_d = NIL;
						end else begin
							tail_d = prv_rd;
							if (ok(prv_rd)) begin
								nxt_we = 1'b1; nxt_a = prv_rd; nxt_d = NIL;
							end
						end
					end
					CMD_DEL_AFTER: begin
						nxt_we = 1'b1; nxt_a = cur_q; nxt_d = nxt_rd;
						if (tail_q == t_q) begin
							tail_d = cur_q;
						end else if (ok(nxt_rd)) begin
							prv_we = 1'b1; prv_a = nxt_rd; prv_d = cur_q;
						end
					end
					CMD_DEL_BEFORE: begin
						prv_we = 1'b1; prv_a = cur_q; prv_d = prv_rd;
						if (head_q == t_q) begin
							head_d = cur_q;
						end else if (ok(prv_rd)) begin
							nxt_we = 1'b1; nxt_a = prv_rd; nxt_d = cur_q;
						end
					end
					CMD_INS_AFTER: begin
						val_we = 1'b1; val_a = n_q;
						prv_we = 1'b1; prv_a = n_q; prv_d = cur_q;
						nxt_we = 1'b1; nxt_a = n_q; nxt_d = norm(nxt_rd);
						u_d    = nxt_rd;
						if (!ok(nxt_rd)) tail_d = n_q;
					end
					CMD_INS_BEFORE: begin
						val_we = 1'b1; val_a = n_q;
						nxt_we = 1'b1; nxt_a = n_q; nxt_d = cur_q;
						prv_we = 1'b1; prv_a = n_q; prv_d = norm(prv_rd);
						u_d    = prv_rd;
						if (!ok(prv_rd)) head_d = n_q;
					end
					default: begin
					end
				endcase
			end
			OP_WR2: begin
				unique case (cmd)
					CMD_INS_FIRST: begin
						if (ok(u_q)) begin
							prv_we = 1'b1; prv_a = u_q; prv_d = n_q;
						end
					end
					CMD_INS_LAST: begin
						if (ok(u_q)) begin
							nxt_we = 1'b1; nxt_a = u_q; nxt_d = n_q;
						end
					end
					CMD_DEL_LAST, CMD_DEL_AFTER, CMD_DEL_BEFORE: begin
						// freed node goes on top of the free list
						nxt_we = 1'b1; nxt_a = t_q; nxt_d = fh_q;
						fh_d   = t_q;
					end
					CMD_INS_AFTER: begin
						nxt_we = 1'b1; nxt_a = cur_q; nxt_d = n_q;
						if (ok(u_q)) begin
							prv_we = 1'b1; prv_a = u_q; prv_d = n_q;
						end
					end
					CMD_INS_BEFORE: begin
						prv_we = 1'b1; prv_a = cur_q; prv_d = n_q;
						if (ok(u_q)) begin
							nxt_we = 1'b1; nxt_a = u_q; nxt_d = n_q;
						end
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase

		res_d.cursor_active = ok(cur_d);
	end

	always_ff @(posedge clk) begin
		if (val_we) val_mem[val_a[AW-1:0]] <= val_d;
		if (val_re) val_rd <= val_mem[val_a[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (nxt_we) nxt_mem[nxt_a[AW-1:0]] <= nxt_d;
		if (nxt_re) nxt_rd <= nxt_mem[nxt_a[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (prv_we) prv_mem[prv_a[AW-1:0]] <= prv_d;
		if (prv_re) prv_rd <= prv_mem[prv_a[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (ctl.latch) req_q <= request;
		if (ctl.finish) res_q <= res_d;
		n_q <= n_d;
		t_q <= t_d;
		u_q <= u_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= NIL;
			tail_q  <= NIL;
			cur_q   <= NIL;
			fh_q    <= NIL;
			fresh_q <= '0;
			take_q  <= 1'b0;
			done    <= 1'b0;
		end else begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			cur_q   <= cur_d;
			fh_q    <= fh_d;
			fresh_q <= fresh_d;
			take_q  <= take_d;
			done    <= ctl.finish;
		end
	end

	assign response = res_q;

endmodule

>>> rtl/cursor_doubly_linked_list.sv
// Top level: doubly linked list with a cursor, controller plus datapath.
`timescale 1ns / 1ps

// Usage
//  - Command channel: drive request (command, value) and raise start; the
//    beat is taken at a rising edge where start is high and busy is low.
//  - Result channel: done is high for exactly one cycle with the result beat
//    on response; the receiver cannot stall it, so it must sample then.
//  - Every command gives exactly one result beat.
//  - Steps: clear, cursor moves, overwrite, failing reads, full inserts and
//    no-op commands run decode only; reads and steps add two reads; inserts
//    and deletes add a free-list pop, link reads and link writes as needed.
//  - Back-to-back: a new command is accepted in the same cycle done is high.
//    How long a command occupies the block is set by its accesses to the
//    single-port value, next-link and prev-link stores: one decode step,
//    at most one free-list pop, up to two link reads and up to two link
//    writes, each in a step of its own.
//  - Reset: list empty, cursor inactive, free list empty, fresh counter at
//    zero. No clearing pass runs; node stores are only read after a write.
//  - Pool capacity is NODES; values are stored on DATA_WIDTH bits and read
//    back sign-extended to 32 bits.
module cursor_doubly_linked_list import cdll_pkg::*; #(
	parameter int NODES      = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  cdll_req_t request,
	output logic      busy,
	output logic      done,
	output cdll_rsp_t response
);

	cdll_ctl_t  ctl;
	cdll_stat_t stat;

	// sequencer: one state per memory access step
	cdll_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.ctl    (ctl),
		.busy   (busy)
	);

	// pool stores, list pointers and the registered result beat
	cdll_dp #(
		.NODES      (NODES),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.request  (request),
		.ctl      (ctl),
		.stat     (stat),
		.done     (done),
		.response (response)
	);

endmodule

>>> tb/cursor_doubly_linked_list_test.sv
// Self-checking testbench for the cursor doubly linked list against a list predictor.
`timescale 1ns / 1ps

module cursor_doubly_linked_list_test import cdll_pkg::*;;

	localparam int         POOL_SIZE   = 64;
	localparam logic [6:0] NULL_NODE   = 7'(POOL_SIZE);
	localparam logic [4:0] CMD_TOP_CODE = 5'd31;   // highest unused command code
	localparam int         CYCLE_LIMIT = 200000;
	localparam int         RANDOM_ITEMS = 1600;

	logic      clk;
	logic      arst_n;
	logic      start;
	cdll_req_t request;
	logic      busy;
	logic      done;
	cdll_rsp_t response;

	cursor_doubly_linked_list dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.request(request),
		.busy(busy),
		.done(done),
		.response(response)
	);

	// Commands waiting to go out, and results the list should produce, oldest first
	cdll_req_t commands_to_send[$];
	cdll_rsp_t expected_results[$];

	int mismatches  = 0;
	int sent_count  = 0;
	int cycle_count = 0;
	logic took_beat;
	logic holding = 1'b0;
	logic stall_now;
	cdll_rsp_t want;

	// ------------------------------------------------------------------
	// List predictor: its own node pool, links, free list and cursor
	// ------------------------------------------------------------------
	logic signed [31:0] pool_value [POOL_SIZE];
	logic [6:0]         pool_next  [POOL_SIZE];
	logic [6:0]         pool_prev  [POOL_SIZE];
	logic [6:0] head_q   = NULL_NODE;
	logic [6:0] tail_q   = NULL_NODE;
	logic [6:0] cursor_q = NULL_NODE;
	logic [6:0] free_q   = NULL_NODE;
	logic [6:0] fresh_q  = '0;

	function automatic logic is_node(logic [6:0] i);
		return i < NULL_NODE;
	endfunction

	function automatic logic [6:0] link_next(logic [6:0] i);
		return is_node(i) ? pool_next[i[5:0]] : NULL_NODE;
	endfunction

	function automatic logic [6:0] link_prev(logic [6:0] i);
		return is_node(i) ? pool_prev[i[5:0]] : NULL_NODE;
	endfunction

	// Free list first, then a never-used node; null when the pool is exhausted
	function automatic logic [6:0] take_node();
		logic [6:0] n;
		if (is_node(free_q)) begin
			n = free_q;
			free_q = pool_next[n[5:0]];
			if (!is_node(free_q))
				free_q = NULL_NODE;
			return n;
		end
		if (fresh_q < NULL_NODE) begin
			n = fresh_q;
			fresh_q = fresh_q + 7'd1;
			return n;
		end
		return NULL_NODE;
	endfunction

	function automatic void release_node(logic [6:0] n);
		if (is_node(n)) begin
			pool_next[n[5:0]] = free_q;
			free_q = n;
		end
	endfunction

	function automatic cdll_rsp_t run_list_command(cdll_req_t req);
		cdll_rsp_t  rsp;
		logic [6:0] n;
		logic [6:0] t;
		logic [6:0] u;
		logic [6:0] rd;
		logic       do_read;
		rsp     = '0;
		do_read = 1'b0;
		rd      = NULL_NODE;
		case (req.command)
			CMD_CLEAR: begin
				head_q   = NULL_NODE;
				tail_q   = NULL_NODE;
				cursor_q = NULL_NODE;
				free_q   = NULL_NODE;
				fresh_q  = '0;
			end
			CMD_INS_FIRST, CMD_INS_LAST: begin
				n = take_node();
				if (!is_node(n)) begin
					rsp.error = ERR_FULL;
				end else begin
					pool_value[n[5:0]] = req.value;
					if (req.command == CMD_INS_FIRST) begin
						pool_prev[n[5:0]] = NULL_NODE;
						pool_next[n[5:0]] = head_q;
						if (is_node(head_q))
							pool_prev[head_q[5:0]] = n;
						else
							tail_q = n;
						head_q = n;
					end else begin
						pool_next[n[5:0]] = NULL_NODE;
						pool_prev[n[5:0]] = tail_q;
						if (is_node(tail_q))
							pool_next[tail_q[5:0]] = n;
						else
							head_q = n;
						tail_q = n;
					end
				end
			end
			CMD_TO_FIRST: cursor_q = head_q;
			CMD_TO_LAST:  cursor_q = tail_q;
			CMD_READ_FIRST: begin
				do_read = 1'b1;
				rd = head_q;
			end
			CMD_READ_LAST: begin
				do_read = 1'b1;
				rd = tail_q;
			end
			CMD_READ_CURSOR: begin
				do_read = 1'b1;
				rd = cursor_q;
			end
			CMD_DEL_FIRST: begin
				if (is_node(head_q)) begin
					t = head_q;
					if (cursor_q == t)
						cursor_q = NULL_NODE;
					if (t == tail_q) begin
						head_q = NULL_NODE;
						tail_q = NULL_NODE;
					end else begin
						head_q = link_next(t);
						if (is_node(head_q))
							pool_prev[head_q[5:0]] = NULL_NODE;
					end
					release_node(t);
				end
			end
			CMD_DEL_LAST: begin
				if (is_node(tail_q)) begin
					t = tail_q;
					if (cursor_q == t)
						cursor_q = NULL_NODE;
					if (t == head_q) begin
						head_q = NULL_NODE;
						tail_q = NULL_NODE;
					end else begin
						tail_q = link_prev(t);
						if (is_node(tail_q))
							pool_next[tail_q[5:0]] = NULL_NODE;
					end
					release_node(t);
				end
			end
			CMD_DEL_AFTER: begin
				t = link_next(cursor_q);
				if (is_node(cursor_q) && cursor_q != tail_q && is_node(t)) begin
					u = link_next(t);
					pool_next[cursor_q[5:0]] = u;
					if (tail_q == t)
						tail_q = cursor_q;
					else if (is_node(u))
						pool_prev[u[5:0]] = cursor_q;
					release_node(t);
				end
			end
			CMD_DEL_BEFORE: begin
				t = link_prev(cursor_q);
				if (is_node(cursor_q) && cursor_q != head_q && is_node(t)) begin
					u = link_prev(t);
					pool_prev[cursor_q[5:0]] = u;
					if (head_q == t)
						head_q = cursor_q;
					else if (is_node(u))
						pool_next[u[5:0]] = cursor_q;
					release_node(t);
				end
			end
			CMD_INS_AFTER, CMD_INS_BEFORE: begin
				// an inactive cursor takes no node and raises no error
				if (is_node(cursor_q)) begin
					n = take_node();
					if (!is_node(n)) begin
						rsp.error = ERR_FULL;
					end else begin
						pool_value[n[5:0]] = req.value;
						if (req.command == CMD_INS_AFTER) begin
							pool_prev[n[5:0]] = cursor_q;
							pool_next[n[5:0]] = link_next(cursor_q);
							pool_next[cursor_q[5:0]] = n;
							u = pool_next[n[5:0]];
							if (is_node(u)) begin
								pool_prev[u[5:0]] = n;
							end else begin
								pool_next[n[5:0]] = NULL_NODE;
								tail_q = n;
							end
						end else begin
							pool_next[n[5:0]] = cursor_q;
							pool_prev[n[5:0]] = link_prev(cursor_q);
							pool_prev[cursor_q[5:0]] = n;
							u = pool_prev[n[5:0]];
							if (is_node(u)) begin
								pool_next[u[5:0]] = n;
							end else begin
								pool_prev[n[5:0]] = NULL_NODE;
								head_q = n;
							end
						end
					end
				end
			end
			CMD_OVERWRITE: begin
				if (is_node(cursor_q))
					pool_value[cursor_q[5:0]] = req.value;
			end
			CMD_STEP_NEXT: begin
				if (is_node(cursor_q))
					cursor_q = link_next(cursor_q);
			end
			CMD_STEP_PREV: begin
				if (is_node(cursor_q))
					cursor_q = link_prev(cursor_q);
			end
			default: ;
		endcase
		if (do_read) begin
			if (is_node(rd)) begin
				rsp.read_value = pool_value[rd[5:0]];
				rsp.read_valid = 1'b1;
			end else begin
				rsp.error = ERR_EMPTY;
			end
		end
		if (!is_node(cursor_q))
			cursor_q = NULL_NODE;
		rsp.cursor_active = is_node(cursor_q);
		return rsp;
	endfunction

	// ------------------------------------------------------------------
	// Clock and reset
	// ------------------------------------------------------------------
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		arst_n  = 1'b0;
		start   = 1'b0;
		request = '0;
	end

	// ------------------------------------------------------------------
	// Driver: a beat is taken when start is high and busy is low at the
	// edge. Start may drop at random, also while busy, so gaps land on
	// every phase of a command. No gaps for beats 500 to 899.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			took_beat = start && !busy;
			if (took_beat) begin
				expected_results.push_back(run_list_command(request));
				sent_count++;
				holding = 1'b0;
			end
			stall_now = (sent_count < 500 || sent_count >= 900) &&
				$urandom_range(99) < 12;
			if (!holding && commands_to_send.size() != 0 && !stall_now) begin
				request <= commands_to_send.pop_front();
				holding = 1'b1;
			end
			start <= holding && !stall_now;
		end
	end

	// ------------------------------------------------------------------
	// Monitor: done marks one result beat that cannot be held off
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result, expected none, actual %p", $time, response);
			end else begin
				want = expected_results.pop_front();
				if (response.read_value !== want.read_value) begin
					mismatches++;
					$display("%0t: read_value expected %0d actual %0d",
						$time, want.read_value, response.read_value);
				end
				if (response.read_valid !== want.read_valid) begin
					mismatches++;
					$display("%0t: read_valid expected %0b actual %0b",
						$time, want.read_valid, response.read_valid);
				end
				if (response.error !== want.error) begin
					mismatches++;
					$display("%0t: error expected %0d actual %0d",
						$time, want.error, response.error);
				end
				if (response.cursor_active !== want.cursor_active) begin
					mismatches++;
					$display("%0t: cursor_active expected %0b actual %0b",
						$time, want.cursor_active, response.cursor_active);
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("cursor_doubly_linked_list: mismatch");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	task automatic queue_command(logic [4:0] cmd, logic signed [31:0] value);
		cdll_req_t req;
		req.command = cmd;
		req.value   = value;
		commands_to_send.push_back(req);
	endtask

	// Random words half the time; max, min, zero and all-ones the other half
	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 7))
			0:       return 32'h7fff_ffff;
			1:       return 32'h8000_0000;
			2:       return 32'h0000_0000;
			3:       return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int         random_count;
		int         mode;
		int         burst;
		logic [4:0] cmd;

		// Directed: empty-list cases, inactive cursor, unknown code,
		// inserts and deletes at both ends around the cursor, walking off.
		queue_command(CMD_READ_FIRST, 0);
		queue_command(CMD_READ_LAST, 0);
		queue_command(CMD_READ_CURSOR, 0);
		queue_command(CMD_DEL_FIRST, 0);
		queue_command(CMD_DEL_LAST, 0);
		queue_command(CMD_INS_AFTER, 32'sd5);
		queue_command(CMD_OVERWRITE, 32'sd6);
		queue_command(CMD_STEP_NEXT, 0);
		queue_command(CMD_TOP_CODE, 32'hffff_ffff);
		queue_command(CMD_INS_FIRST, 32'h7fff_ffff);
		queue_command(CMD_INS_LAST, 32'h8000_0000);
		queue_command(CMD_TO_FIRST, 0);
		queue_command(CMD_INS_BEFORE, 0);        // new head
		queue_command(CMD_DEL_BEFORE, 0);        // drops it, head back on cursor
		queue_command(CMD_DEL_BEFORE, 0);        // cursor is head: no-op
		queue_command(CMD_TO_LAST, 0);
		queue_command(CMD_INS_AFTER, 32'hffff_ffff);  // new tail
		queue_command(CMD_DEL_AFTER, 0);         // tail back on cursor
		queue_command(CMD_DEL_AFTER, 0);         // cursor is tail: no-op
		queue_command(CMD_OVERWRITE, 32'h1234_5678);
		queue_command(CMD_READ_CURSOR, 0);
		queue_command(CMD_STEP_PREV, 0);
		queue_command(CMD_STEP_PREV, 0);         // off the front, inactive
		queue_command(CMD_TO_FIRST, 0);
		queue_command(CMD_DEL_FIRST, 0);         // deletes node under cursor
		queue_command(CMD_CLEAR, 0);

		// Random: bursts biased toward growing, shrinking or walking the
		// list, some noise, and refills that run the pool dry.
		random_count = 0;
		mode = 0;
		while (random_count < RANDOM_ITEMS) begin
			burst = $urandom_range(10, 60);
			if (mode == 0) begin
				// refill past capacity to hit the pool-full error
				if ($urandom_range(1))
					queue_command(CMD_CLEAR, pick_value());
				queue_command(CMD_INS_LAST, pick_value());
				queue_command(CMD_TO_FIRST, pick_value());
				burst = 70;
			end
			repeat (burst) begin
				case (mode)
					0: begin
						case ($urandom_range(0, 3))
							0:       cmd = CMD_INS_FIRST;
							1:       cmd = CMD_INS_LAST;
							2:       cmd = CMD_INS_AFTER;
							default: cmd = CMD_INS_BEFORE;
						endcase
					end
					1: begin
						case ($urandom_range(0, 9))
							0, 1, 2: cmd = CMD_INS_LAST;
							3, 4:    cmd = CMD_INS_FIRST;
							5, 6:    cmd = CMD_INS_AFTER;
							7:       cmd = CMD_INS_BEFORE;
							8:       cmd = CMD_TO_FIRST;
							default: cmd = CMD_TO_LAST;
						endcase
					end
					2: begin
						case ($urandom_range(0, 9))
							0, 1:    cmd = CMD_DEL_FIRST;
							2, 3:    cmd = CMD_DEL_LAST;
							4, 5:    cmd = CMD_DEL_AFTER;
							6, 7:    cmd = CMD_DEL_BEFORE;
							8:       cmd = CMD_TO_FIRST;
							default: cmd = CMD_STEP_PREV;
						endcase
					end
					3: begin
						case ($urandom_range(0, 10))
							0:       cmd = CMD_TO_FIRST;
							1:       cmd = CMD_TO_LAST;
							2, 3:    cmd = CMD_STEP_NEXT;
							4:       cmd = CMD_STEP_PREV;
							5:       cmd = CMD_READ_CURSOR;
							6:       cmd = CMD_OVERWRITE;
							7:       cmd = CMD_READ_FIRST;
							8:       cmd = CMD_READ_LAST;
							9:       cmd = CMD_INS_BEFORE;
							default: cmd = CMD_DEL_AFTER;
						endcase
					end
					default: cmd = 5'($urandom_range(0, 31));
				endcase
				queue_command(cmd, pick_value());
				// unknown codes are ignored by the block and do not count
				if (cmd <= CMD_STEP_PREV)
					random_count++;
			end
			burst = $urandom_range(0, 99);
			if (burst < 6)
				mode = 0;
			else if (burst < 36)
				mode = 1;
			else if (burst < 60)
				mode = 2;
			else if (burst < 90)
				mode = 3;
			else
				mode = 4;
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: everything sent, every result back, then a latency margin
		while (commands_to_send.size() != 0 || holding)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);

		if (mismatches == 0 && expected_results.size() == 0)
			$display("cursor_doubly_linked_list: match");
		else
			$display("cursor_doubly_linked_list: mismatch");
		$finish;
	end

endmodule
